// ===== design/hpss_pkg.sv =====
// hpss_pkg: shared types and constants for the hex pair sum stream core
// no dependencies; imported by hpss_fmt, hex_pair_sum_stream_core, hpss_checker and the testbench
package hpss_pkg;

    localparam int TOK_W   = 64;
    localparam int DIG_W   = 4;
    localparam int NUM_DIG = TOK_W / DIG_W;
    localparam int CNT_W   = $clog2(NUM_DIG);

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] SEP_MAX   = 8'h20;
    localparam logic [3:0] HEX_ADJ   = 4'd9;
    localparam logic [7:0] DEC_RADIX = 8'd10;

    localparam logic [7:0] HEX_CHARS [NUM_DIG] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // parse position within the text stream
    typedef enum logic [2:0] {
        PH_SKIP_COUNT = 3'd0,
        PH_COUNT      = 3'd1,
        PH_SKIP_A     = 3'd2,
        PH_A          = 3'd3,
        PH_SKIP_B     = 3'd4,
        PH_B          = 3'd5,
        PH_DONE       = 3'd6
    } t_phase;

    // sequencer for the nibble-serial datapath
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_ADD,
        SEQ_EMIT,
        SEQ_NL
    } t_seq;

    // one character request to the output stage
    typedef struct packed {
        logic             load;
        logic             nl;
        logic [DIG_W-1:0] nib;
    } t_char_req;

endpackage

// ===== design/hex_pair_sum_stream_core.sv =====
// hex_pair_sum_stream_core: ascii pair-count / hex pair parser that prints each sum in hex
// depends on hpss_pkg and hpss_fmt
//
// Takes one text byte per transfer. Separators and hex digits are taken one per cycle while
// o_in_stall is low. A digit of the leading decimal count stalls the input while the
// multiply by ten runs over the 64-bit token one nibble per cycle. When the second token of
// a pair ends, the sum and the pair-count decrement run nibble-serially, then the core walks
// the 16 sum nibbles from the top (leading zeros are not printed) and sends the newline, so
// a pair end holds the input until the newline is loaded into the output register. A
// one-character output register keeps the output side apart from the parser. No clearing pass after reset.
module hex_pair_sum_stream_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import hpss_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_DIG - 1);

    t_seq             r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [TOK_W-1:0] r_tok, n_tok;
    logic [TOK_W-1:0] r_first, n_first;
    logic [TOK_W-1:0] r_pairs, n_pairs;
    logic [7:0]       r_diff, n_diff;
    logic [3:0]       r_carry, n_carry;
    logic             r_borrow, n_borrow;
    logic             r_nz, n_nz;
    logic             r_eoi, n_eoi;
    logic             r_started, n_started;

    t_char_req        req;
    logic             fmt_free;

    logic             in_fire;
    logic             sep;
    logic             skip;
    logic             done;
    t_phase           p_eff;
    logic [TOK_W-1:0] tok_eff;
    logic [3:0]       hex_nib;
    logic             go_add;
    logic             go_mul;

    logic [3:0]       add_nib;
    logic [7:0]       prod;
    logic [4:0]       sum5;
    logic [3:0]       dec_nib;
    logic [3:0]       top_nib;
    logic             show;
    logic             advance;

    assign o_in_stall = (r_state != SEQ_IDLE);
    assign in_fire    = i_in_valid && (r_state == SEQ_IDLE);
    assign sep        = (i_in_byte <= SEP_MAX) || i_in_byte[7];

    always_comb begin
        skip  = 1'b0;
        done  = 1'b0;
        p_eff = r_phase;
        case (r_phase)
            PH_SKIP_COUNT: begin
                skip  = 1'b1;
                p_eff = sep ? PH_SKIP_COUNT : PH_COUNT;
            end
            PH_SKIP_A: begin
                skip  = 1'b1;
                p_eff = sep ? PH_SKIP_A : PH_A;
            end
            PH_SKIP_B: begin
                skip  = 1'b1;
                p_eff = sep ? PH_SKIP_B : PH_B;
            end
            PH_COUNT, PH_A, PH_B: begin
                p_eff = r_phase;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    assign tok_eff = skip ? '0 : r_tok;
    assign hex_nib = (i_in_byte <= CH_NINE) ? i_in_byte[3:0] : (i_in_byte[3:0] + HEX_ADJ);

    // end of stream inside a second operand still closes the pair
    assign go_add = !done && ((sep && r_phase == PH_B) ||
                              (!sep && i_end_of_input && p_eff == PH_B));
    assign go_mul = !done && !sep && !i_end_of_input && p_eff == PH_COUNT;

    // nibble-serial datapath pieces
    always_comb begin
        case (r_cnt)
            CNT_W'(0): add_nib = r_diff[3:0];
            CNT_W'(1): add_nib = r_diff[7:4];
            default:   add_nib = {4{r_diff[7]}};
        endcase
    end

    assign prod    = ({4'b0, r_tok[3:0]} * DEC_RADIX) + {4'b0, add_nib} + {4'b0, r_carry};
    assign sum5    = {1'b0, r_first[3:0]} + {1'b0, r_tok[3:0]} + {4'b0, r_carry[0]};
    assign dec_nib = r_pairs[3:0] - {3'b0, r_borrow};
    assign top_nib = r_first[TOK_W-1 -: DIG_W];
    assign show    = r_started || (top_nib != 4'd0) || (r_cnt == CNT_LAST);
    assign advance = show ? fmt_free : 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: begin
                if (in_fire && go_add) begin
                    n_state = SEQ_ADD;
                end else if (in_fire && go_mul) begin
                    n_state = SEQ_MUL;
                end
            end
            SEQ_MUL: begin
                if (r_cnt == CNT_LAST) n_state = SEQ_IDLE;
            end
            SEQ_ADD: begin
                if (r_cnt == CNT_LAST) n_state = SEQ_EMIT;
            end
            SEQ_EMIT: begin
                if (advance && r_cnt == CNT_LAST) n_state = SEQ_NL;
            end
            SEQ_NL: begin
                if (fmt_free) n_state = SEQ_IDLE;
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    // character requests to the output stage
    always_comb begin
        req = '0;
        case (r_state)
            SEQ_EMIT: begin
                req.load = show && fmt_free;
                req.nib  = top_nib;
            end
            SEQ_NL: begin
                req.load = fmt_free;
                req.nl   = 1'b1;
            end
            default: begin
                req = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_tok     = r_tok;
        n_first   = r_first;
        n_pairs   = r_pairs;
        n_diff    = r_diff;
        n_carry   = r_carry;
        n_borrow  = r_borrow;
        n_nz      = r_nz;
        n_eoi     = r_eoi;
        n_started = r_started;
        case (r_state)
            SEQ_IDLE: begin
                if (in_fire) begin
                    n_eoi     = i_end_of_input;
                    n_cnt     = '0;
                    n_carry   = '0;
                    n_borrow  = 1'b1;
                    n_nz      = 1'b0;
                    n_started = 1'b0;
                    if (!done && sep) begin
                        case (r_phase)
                            PH_COUNT: begin
                                n_pairs = r_tok;
                                n_phase = (r_tok == '0) ? PH_DONE : PH_SKIP_A;
                            end
                            PH_A: begin
                                n_first = r_tok;
                                n_phase = PH_SKIP_B;
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end else if (!done) begin
                        n_phase = p_eff;
                        if (p_eff == PH_COUNT) begin
                            n_tok  = tok_eff;
                            n_diff = i_in_byte - CH_ZERO;
                        end else begin
                            n_tok = {tok_eff[TOK_W-DIG_W-1:0], hex_nib};
                        end
                    end
                    // stream end returns to the start unless a sum is still to be printed
                    if (i_end_of_input && !go_add) n_phase = PH_SKIP_COUNT;
                end
            end
            SEQ_MUL: begin
                n_tok   = {prod[3:0], r_tok[TOK_W-1:DIG_W]};
                n_carry = prod[7:4];
                n_cnt   = r_cnt + CNT_W'(1);
            end
            SEQ_ADD: begin
                n_first  = {sum5[3:0], r_first[TOK_W-1:DIG_W]};
                n_tok    = {r_tok[DIG_W-1:0], r_tok[TOK_W-1:DIG_W]};
                n_carry  = {3'b0, sum5[4]};
                n_pairs  = {dec_nib, r_pairs[TOK_W-1:DIG_W]};
                n_borrow = r_borrow && (r_pairs[3:0] == 4'd0);
                n_nz     = r_nz || (dec_nib != 4'd0);
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    if (r_eoi) begin
                        n_phase = PH_SKIP_COUNT;
                    end else begin
                        n_phase = (r_nz || (dec_nib != 4'd0)) ? PH_SKIP_A : PH_DONE;
                    end
                end
            end
            SEQ_EMIT: begin
                if (advance) begin
                    n_first   = {r_first[TOK_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    n_cnt     = r_cnt + CNT_W'(1);
                    n_started = r_started || show;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_phase <= PH_SKIP_COUNT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok     <= n_tok;
        r_first   <= n_first;
        r_pairs   <= n_pairs;
        r_diff    <= n_diff;
        r_carry   <= n_carry;
        r_borrow  <= n_borrow;
        r_nz      <= n_nz;
        r_eoi     <= n_eoi;
        r_started <= n_started;
    end

    hpss_fmt u_fmt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_free      (fmt_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

// ===== design/hpss_fmt.sv =====
// hpss_fmt: output register that turns nibble / newline requests into ascii characters
// depends on hpss_pkg (t_char_req, HEX_CHARS, CH_NL)
module hpss_fmt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hpss_pkg::t_char_req i_req,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_last
);
    import hpss_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // slot can take a new character when empty or when the held one transfers now
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_byte <= i_req.nl ? CH_NL : HEX_CHARS[i_req.nib];
            r_last <= i_req.nl;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last      = r_last;

endmodule

// ===== test/hpss_checker.sv =====
// hpss_checker: watches both channels of hex_pair_sum_stream_core, predicts the printed sums
// and compares every output transfer against them; depends on hpss_pkg
module hpss_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);
    import hpss_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    // parser copy kept by the checker
    t_phase      phase_q;
    logic [63:0] pairs_left;
    logic [63:0] first_operand;
    logic [63:0] token_value;

    t_out_char   expected_chars[$];
    t_out_char   want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_error(input string msg);
        if (o_fail_count < 40)
            $display("[%0t] checker: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic clear_parser();
        phase_q       = PH_SKIP_COUNT;
        pairs_left    = '0;
        first_operand = '0;
        token_value   = '0;
    endtask

    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] d;
        if (b <= CH_NINE)
            d = b - CH_ZERO;
        else
            d = (b | 8'h20) - 8'h61 + 8'd10;
        return d[3:0];
    endfunction

    // lowercase hex of the sum without leading zeros, then the newline
    task automatic queue_sum_text(input logic [63:0] sum);
        logic       started;
        logic [3:0] nib;
        int         sh;
        started = 1'b0;
        for (sh = 60; sh >= 0; sh -= 4) begin
            nib = sum[sh +: 4];
            if (nib != 4'd0)
                started = 1'b1;
            if (started)
                // 8'h57 is 'a' minus ten
                expected_chars.push_back('{nib < 4'd10 ? CH_ZERO + {4'd0, nib}
                                                       : 8'h57 + {4'd0, nib}, 1'b0});
        end
        if (!started)
            expected_chars.push_back('{CH_ZERO, 1'b0});
        expected_chars.push_back('{CH_NL, 1'b1});
    endtask

    task automatic close_token();
        case (phase_q)
            PH_COUNT: begin
                pairs_left = token_value;
                phase_q    = (pairs_left == 64'd0) ? PH_DONE : PH_SKIP_A;
            end
            PH_A: begin
                first_operand = token_value;
                phase_q       = PH_SKIP_B;
            end
            PH_B: begin
                queue_sum_text(first_operand + token_value);
                pairs_left = pairs_left - 64'd1;
                phase_q    = (pairs_left == 64'd0) ? PH_DONE : PH_SKIP_A;
            end
            default: ;
        endcase
        token_value = '0;
    endtask

    task automatic predict_text(input logic [7:0] b, input logic eoi);
        if (phase_q != PH_DONE) begin
            if (b <= SEP_MAX || b[7]) begin
                if (phase_q inside {PH_COUNT, PH_A, PH_B})
                    close_token();
            end else begin
                if (phase_q inside {PH_SKIP_COUNT, PH_SKIP_A, PH_SKIP_B}) begin
                    token_value = '0;
                    phase_q     = t_phase'(phase_q + 3'd1);
                end
                // the count takes any non-separator byte as a signed digit
                if (phase_q == PH_COUNT)
                    token_value = token_value * 64'd10 + {56'd0, b} - 64'h30;
                else
                    token_value = {token_value[59:0], hex_nibble(b)};
            end
        end
        if (eoi) begin
            if (phase_q == PH_B)
                close_token();
            clear_parser();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            expected_chars.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    report_error($sformatf("unexpected output transfer byte %h last %b",
                                           i_out_byte, i_last));
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_byte !== want.ch)
                        report_error($sformatf("out_byte %h, want %h", i_out_byte, want.ch));
                    if (i_last !== want.last)
                        report_error($sformatf("last %b, want %b (byte %h)",
                                               i_last, want.last, want.ch));
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_text(i_in_byte, i_end_of_input);
        end
        o_pending <= expected_chars.size();
    end

endmodule

// ===== test/hex_pair_sum_stream_core_tb.sv =====
// hex_pair_sum_stream_core_tb: drives text streams into hex_pair_sum_stream_core with random
// gaps and output stalls; depends on hpss_pkg, the core and hpss_checker
module hex_pair_sum_stream_core_tb;
    import hpss_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TARGET_ITEMS = 150;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       end_of_input;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last;

    int         fail_count;
    int         pending;
    int         cycle_count   = 0;
    int         sent_items    = 0;
    int         hold_requests = 0;
    bit         calm          = 1'b0;
    logic [7:0] stream_bytes[$];

    hex_pair_sum_stream_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_end_of_input (end_of_input),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (out_byte),
        .o_last         (last)
    );

    hpss_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_end_of_input (end_of_input),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_byte     (out_byte),
        .i_last         (last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold-off per request
    initial begin : receiver
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < 14);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        while (!calm && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        do @(posedge clk); while (in_stall);
        sent_items++;
    endtask

    // end_of_input rides on the last byte of the stream
    task automatic send_stream();
        int k;
        for (k = 0; k < stream_bytes.size(); k++)
            send_byte(stream_bytes[k], k == stream_bytes.size() - 1);
        stream_bytes.delete();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            stream_bytes.push_back(s[i]);
    endtask

    task automatic add_separators();
        int n;
        int r;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
        repeat (n) begin
            r = $urandom_range(0, 2);
            if (r == 0)
                stream_bytes.push_back(8'h20);
            else if (r == 1)
                stream_bytes.push_back(8'($urandom_range(0, 32)));
            else
                stream_bytes.push_back(8'($urandom_range(128, 255)));
        end
    endtask

    // mostly hex digits in either case, now and then a random byte from 8'h21 to 8'h7F
    task automatic add_token();
        int         len;
        logic [3:0] v;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
        repeat (len) begin
            v = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0)
                stream_bytes.push_back(8'($urandom_range(33, 127)));
            else if (v < 4'd10)
                stream_bytes.push_back(CH_ZERO + {4'd0, v});
            else
                stream_bytes.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, v}
                                       - 8'd10);
        end
    endtask

    task automatic send_random_stream(input bit clean, input int max_pairs);
        int shape;
        int npairs;
        int n;
        shape = clean ? 99 : $urandom_range(0, 99);
        if (shape < 8) begin
            // pure noise
            n = $urandom_range(1, 10);
            repeat (n) stream_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0)
                add_separators();
            npairs = (!clean && $urandom_range(0, 24) == 0) ? 0 : $urandom_range(1, max_pairs);
            if (!clean && $urandom_range(0, 19) == 0)
                stream_bytes.push_back(8'($urandom_range(33, 127)));
            else if ($urandom_range(0, 9) == 0)
                add_text($sformatf("0%0d", npairs));
            else
                add_text($sformatf("%0d", npairs));
            repeat (npairs) begin
                add_separators();
                add_token();
                add_separators();
                add_token();
            end
            if (shape < 25) begin
                // broken stream: cut anywhere
                n = $urandom_range(1, stream_bytes.size());
                while (stream_bytes.size() > n)
                    void'(stream_bytes.pop_back());
            end else if (shape < 50) begin
                add_separators();
                add_token();
            end else if (shape < 75) begin
                add_separators();
            end
        end
        send_stream();
    endtask

    initial begin : stimulus
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_byte      <= 8'h00;
        end_of_input <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // separator extremes, odd nibble bytes, stream end inside the second operand
        stream_bytes.push_back(8'h00);
        add_text("1");
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'h7F);
        stream_bytes.push_back(8'h21);
        stream_bytes.push_back(8'h20);
        add_text("G");
        send_stream();
        // zero count: rest ignored
        add_text("0 a b");
        send_stream();
        // stream end inside the count
        add_text("99");
        send_stream();
        // stream end inside a first operand
        add_text("1 a");
        send_stream();
        // zero sum, then input after the last pair
        add_text("1 0 0 55");
        send_stream();
        drain();

        while (sent_items < 80)
            send_random_stream(1'b0, 4);

        // long output hold-off while the sender keeps going
        hold_requests <= hold_requests + 1;
        repeat (2) send_random_stream(1'b1, 4);
        drain();

        calm <= 1'b1;
        while (sent_items < 130)
            send_random_stream(1'b0, 4);
        calm <= 1'b0;

        while (sent_items < TARGET_ITEMS)
            send_random_stream(1'b0, 4);
        drain();
        repeat (100) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
